// ===== rtl/sprite_frame_sequencer_macros.svh =====
// ----------------------------------------------------------------------------
// sprite_frame_sequencer_macros.svh
// assertion macros for the sprite frame sequencer rtl
// ----------------------------------------------------------------------------
`ifndef SPRITE_FRAME_SEQUENCER_MACROS_SVH
`define SPRITE_FRAME_SEQUENCER_MACROS_SVH

// same-cycle implication, checked on clk, quiet while rst_n is low
`define SFS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sprite frame sequencer check failed");

// next-cycle implication, checked on clk, quiet while rst_n is low
`define SFS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sprite frame sequencer check failed");

`endif

// ===== rtl/sfs_pkg.sv =====
// ----------------------------------------------------------------------------
// sfs_pkg
// shared constants, codes and types of the sprite frame sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package sfs_pkg;

  localparam int CHANNELS    = 4;
  localparam int MAX_FRAMES  = 64;
  localparam int ADDRESSABLE = 4;
  localparam int LANES       = (CHANNELS < ADDRESSABLE) ? CHANNELS : ADDRESSABLE;

  localparam int FRAME_W     = $clog2(MAX_FRAMES);
  localparam int LEN_W       = $clog2(MAX_FRAMES + 1);
  localparam int IDX_W       = (LANES > 1) ? $clog2(LANES) : 1;

  localparam int ACT_W       = 3;
  localparam int CH_W        = 2;
  localparam int FCOUNT_W    = 7;
  localparam int FNUM_W      = 6;
  localparam int DUR_W       = 16;
  localparam int MASK_W      = 4;
  localparam int OUT_FRAME_W = 6;

  typedef enum logic [ACT_W-1:0] {
    ACT_TICK      = 3'd0,
    ACT_BIND      = 3'd1,
    ACT_UNBIND    = 3'd2,
    ACT_RESET_ALL = 3'd3,
    ACT_LOAD      = 3'd4
  } action_t;

  // broadcast from the decoder to every lane
  typedef struct packed {
    logic                do_tick;
    logic                do_bind;
    logic                do_unbind;
    logic                do_clear;
    logic                do_load;
    logic [LEN_W-1:0]    seq_len;
    logic                loop_en;
    logic [FRAME_W-1:0]  frame;
    logic [DUR_W-1:0]    dur;
  } lane_cmd_t;

  // what one lane found on the last tick
  typedef struct packed {
    logic                   shown;
    logic                   slot;
    logic [OUT_FRAME_W-1:0] frame;
  } lane_res_t;

  // start of a new transaction for the result merger
  typedef struct packed {
    logic            fire;
    logic            tick;
    logic [CH_W-1:0] battler;
    logic            accepted;
  } merge_req_t;

  function automatic logic chan_ok(input logic [CH_W-1:0] ch);
    return int'(ch) < CHANNELS;
  endfunction

  function automatic logic fcount_ok(input logic [FCOUNT_W-1:0] fcount);
    return (fcount != '0) && (int'(fcount) <= MAX_FRAMES);
  endfunction

  function automatic logic fnum_ok(input logic [FNUM_W-1:0] fnum);
    return int'(fnum) < MAX_FRAMES;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sfs_ram.sv =====
// ----------------------------------------------------------------------------
// sfs_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/sfs_lane.sv =====
// ----------------------------------------------------------------------------
// sfs_lane
// one animation channel: sequencing state, duration store and tick decision
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_lane (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire sfs_pkg::lane_cmd_t cmd,
  input  wire logic               sel,
  input  wire logic               can_present,
  input  wire logic               stage_ok,
  output sfs_pkg::lane_res_t      res
);

  logic                              bound_r, bound_nxt;
  logic [sfs_pkg::LEN_W-1:0]         len_r, len_nxt;
  logic                              loop_r, loop_nxt;
  logic [sfs_pkg::DUR_W-1:0]         ticks_r, ticks_nxt;
  logic [sfs_pkg::FRAME_W-1:0]       cur_r, cur_nxt;
  logic                              slot_r, slot_nxt;
  logic                              started_r, started_nxt;
  logic                              refresh_r, refresh_nxt;
  logic                              stage_pend_r, stage_pend_nxt;
  sfs_pkg::lane_res_t                res_r, res_nxt;

  logic [sfs_pkg::LEN_W-1:0]         nf;
  logic                              stage_req;
  logic [sfs_pkg::FRAME_W-1:0]       stage_f;
  logic                              stage_s;
  logic                              shown;
  logic [sfs_pkg::FRAME_W-1:0]       rd_addr;
  logic [sfs_pkg::DUR_W-1:0]         rd_data;

  sfs_ram #(
    .WIDTH (sfs_pkg::DUR_W),
    .DEPTH (sfs_pkg::MAX_FRAMES)
  ) u_dur_ram (
    .clk   (clk),
    .we    (cmd.do_load && sel),
    .waddr (cmd.frame),
    .wdata (cmd.dur),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    bound_nxt      = bound_r;
    len_nxt        = len_r;
    loop_nxt       = loop_r;
    ticks_nxt      = ticks_r;
    cur_nxt        = cur_r;
    slot_nxt       = slot_r;
    started_nxt    = started_r;
    refresh_nxt    = refresh_r;
    stage_pend_nxt = 1'b0;
    res_nxt        = res_r;
    rd_addr        = cur_r;
    nf             = sfs_pkg::LEN_W'(cur_r) + sfs_pkg::LEN_W'(1);
    stage_req      = 1'b0;
    stage_f        = '0;
    stage_s        = 1'b0;
    shown          = 1'b0;

    // duration of a frame staged on the previous tick arrives from the ram
    if (stage_pend_r) begin
      ticks_nxt = (rd_data == '0) ? sfs_pkg::DUR_W'(1) : rd_data;
    end

    if (cmd.do_clear || (sel && (cmd.do_unbind || cmd.do_bind))) begin
      bound_nxt   = 1'b0;
      len_nxt     = '0;
      loop_nxt    = 1'b0;
      ticks_nxt   = '0;
      cur_nxt     = '0;
      slot_nxt    = 1'b0;
      started_nxt = 1'b0;
      refresh_nxt = 1'b0;
    end
    if (sel && cmd.do_bind) begin
      bound_nxt = 1'b1;
      len_nxt   = cmd.seq_len;
      loop_nxt  = cmd.loop_en;
    end

    if (cmd.do_tick && bound_r) begin
      if (!can_present) begin
        if (started_r) begin
          refresh_nxt = 1'b1;
        end
      end else if (!started_r) begin
        stage_req = 1'b1;
      end else if (refresh_r) begin
        if ((sfs_pkg::LEN_W'(cur_r) < len_r) && stage_ok) begin
          refresh_nxt = 1'b0;
          shown       = 1'b1;
        end
      end else if (ticks_r > sfs_pkg::DUR_W'(1)) begin
        ticks_nxt = ticks_r - sfs_pkg::DUR_W'(1);
      end else if (nf >= len_r) begin
        // end of sequence: wrap when looping, otherwise hold the last frame
        if (loop_r) begin
          stage_req = 1'b1;
          stage_s   = ~slot_r;
        end else begin
          ticks_nxt = sfs_pkg::DUR_W'(1);
        end
      end else begin
        stage_req = 1'b1;
        stage_f   = sfs_pkg::FRAME_W'(nf);
        stage_s   = ~slot_r;
      end

      if (stage_req && (sfs_pkg::LEN_W'(stage_f) < len_r) && stage_ok) begin
        cur_nxt        = stage_f;
        slot_nxt       = stage_s;
        started_nxt    = 1'b1;
        refresh_nxt    = 1'b0;
        stage_pend_nxt = 1'b1;
        rd_addr        = stage_f;
        shown          = 1'b1;
      end
    end

    if (cmd.do_tick) begin
      if (shown) begin
        res_nxt.shown = 1'b1;
        res_nxt.slot  = slot_nxt;
        res_nxt.frame = sfs_pkg::OUT_FRAME_W'(cur_nxt);
      end else begin
        res_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bound_r      <= 1'b0;
      len_r        <= '0;
      loop_r       <= 1'b0;
      ticks_r      <= '0;
      cur_r        <= '0;
      slot_r       <= 1'b0;
      started_r    <= 1'b0;
      refresh_r    <= 1'b0;
      stage_pend_r <= 1'b0;
    end else begin
      bound_r      <= bound_nxt;
      len_r        <= len_nxt;
      loop_r       <= loop_nxt;
      ticks_r      <= ticks_nxt;
      cur_r        <= cur_nxt;
      slot_r       <= slot_nxt;
      started_r    <= started_nxt;
      refresh_r    <= refresh_nxt;
      stage_pend_r <= stage_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule

`default_nettype wire

// ===== rtl/sfs_merge.sv =====
// ----------------------------------------------------------------------------
// sfs_merge
// walks the lane results in channel order into the output register, or loads the single result of a non-tick action
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_merge (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire sfs_pkg::merge_req_t                  req,
  input  wire sfs_pkg::lane_res_t                   lane_res [sfs_pkg::LANES],
  input  wire logic                                 out_stall,
  output logic                                      can_accept,
  output logic                                      out_valid,
  output logic [sfs_pkg::CH_W-1:0]                  out_battler,
  output logic                                      out_shown,
  output logic                                      out_buffer_slot,
  output logic [sfs_pkg::OUT_FRAME_W-1:0]           out_shown_frame,
  output logic                                      out_accepted,
  output logic                                      out_last_result
);

  typedef enum logic {
    S_IDLE,
    S_EMIT
  } state_t;

  localparam logic [sfs_pkg::IDX_W-1:0] LAST_IDX = sfs_pkg::IDX_W'(sfs_pkg::LANES - 1);

  state_t                           state_r;
  logic [sfs_pkg::IDX_W-1:0]        idx_r;
  logic                             tick_mode_r;
  logic [sfs_pkg::CH_W-1:0]         nt_battler_r;
  logic                             nt_acc_r;
  logic                             out_valid_r;
  logic [sfs_pkg::CH_W-1:0]         out_battler_r;
  logic                             out_shown_r;
  logic                             out_slot_r;
  logic [sfs_pkg::OUT_FRAME_W-1:0]  out_frame_r;
  logic                             out_acc_r;
  logic                             out_last_r;

  logic                             out_free;
  logic                             is_last;
  logic                             emit_now;
  sfs_pkg::lane_res_t               sel_res;

  always_comb begin
    out_free   = !out_valid_r || !out_stall;
    is_last    = !tick_mode_r || (idx_r == LAST_IDX);
    emit_now   = (state_r == S_EMIT) && out_free;
    // the next transaction may enter on the cycle the last result is loaded
    can_accept = (state_r == S_IDLE) || (emit_now && is_last);
    sel_res    = lane_res[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      idx_r         <= '0;
      tick_mode_r   <= 1'b0;
      nt_battler_r  <= '0;
      nt_acc_r      <= 1'b0;
      out_valid_r   <= 1'b0;
      out_battler_r <= '0;
      out_shown_r   <= 1'b0;
      out_slot_r    <= 1'b0;
      out_frame_r   <= '0;
      out_acc_r     <= 1'b0;
      out_last_r    <= 1'b0;
    end else begin
      if (emit_now) begin
        out_valid_r <= 1'b1;
        out_last_r  <= is_last;
        if (tick_mode_r) begin
          out_battler_r <= sfs_pkg::CH_W'(idx_r);
          out_shown_r   <= sel_res.shown;
          out_slot_r    <= sel_res.slot;
          out_frame_r   <= sel_res.frame;
          out_acc_r     <= 1'b0;
        end else begin
          out_battler_r <= nt_battler_r;
          out_shown_r   <= 1'b0;
          out_slot_r    <= 1'b0;
          out_frame_r   <= '0;
          out_acc_r     <= nt_acc_r;
        end
        if (is_last) begin
          state_r <= S_IDLE;
        end else begin
          idx_r <= idx_r + sfs_pkg::IDX_W'(1);
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (req.fire) begin
        state_r      <= S_EMIT;
        idx_r        <= '0;
        tick_mode_r  <= req.tick;
        nt_battler_r <= req.battler;
        nt_acc_r     <= req.accepted;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_battler     = out_battler_r;
  assign out_shown       = out_shown_r;
  assign out_buffer_slot = out_slot_r;
  assign out_shown_frame = out_frame_r;
  assign out_accepted    = out_acc_r;
  assign out_last_result = out_last_r;

endmodule

`default_nettype wire

// ===== rtl/sprite_frame_sequencer.sv =====
// ----------------------------------------------------------------------------
// sprite_frame_sequencer: per-channel animation frame sequencer
// first result: a taken transaction puts the merger in its emit state, and the first
// result is then loaded into the output register once that register is free
// throughput: a tick gives one result per channel, one per cycle through the single output register
//   while out_stall is low; any other action gives a single result
// reset: synchronous rst_n clears channel state and control; duration rams keep contents
`default_nettype none

`include "sprite_frame_sequencer_macros.svh"

module sprite_frame_sequencer (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,

  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [sfs_pkg::ACT_W-1:0]            in_action,
  input  wire logic [sfs_pkg::CH_W-1:0]             in_battler,
  input  wire logic [sfs_pkg::FCOUNT_W-1:0]         in_frame_count,
  input  wire logic                                 in_loop_enable,
  input  wire logic [sfs_pkg::FNUM_W-1:0]           in_frame_number,
  input  wire logic [sfs_pkg::DUR_W-1:0]            in_duration,
  input  wire logic [sfs_pkg::MASK_W-1:0]           in_can_present_mask,
  input  wire logic [sfs_pkg::MASK_W-1:0]           in_stage_ok_mask,

  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [sfs_pkg::CH_W-1:0]                  out_battler,
  output logic                                      out_shown,
  output logic                                      out_buffer_slot,
  output logic [sfs_pkg::OUT_FRAME_W-1:0]           out_shown_frame,
  output logic                                      out_accepted,
  output logic                                      out_last_result
);

  logic                  in_fire;
  logic                  can_accept;
  logic                  commit_r;
  logic                  chan_in_range;
  logic                  blank_fields;
  sfs_pkg::lane_cmd_t    cmd;
  sfs_pkg::merge_req_t   req;
  sfs_pkg::lane_res_t    lane_res [sfs_pkg::LANES];

  // the cycle after a tick the lanes take durations from their rams
  assign in_stall = !can_accept || commit_r;
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    chan_in_range = sfs_pkg::chan_ok(in_battler);
    cmd           = '0;
    cmd.seq_len   = sfs_pkg::LEN_W'(in_frame_count);
    cmd.loop_en   = in_loop_enable;
    cmd.frame     = sfs_pkg::FRAME_W'(in_frame_number);
    cmd.dur       = in_duration;
    req           = '0;
    req.fire      = in_fire;
    req.battler   = in_battler;

    unique case (in_action)
      sfs_pkg::ACT_TICK: begin
        cmd.do_tick = in_fire;
        req.tick    = 1'b1;
      end
      sfs_pkg::ACT_BIND: begin
        req.accepted = chan_in_range && sfs_pkg::fcount_ok(in_frame_count);
        cmd.do_bind  = in_fire && req.accepted;
      end
      sfs_pkg::ACT_UNBIND: begin
        req.accepted  = chan_in_range;
        cmd.do_unbind = in_fire && req.accepted;
      end
      sfs_pkg::ACT_RESET_ALL: begin
        req.accepted = 1'b1;
        req.battler  = '0;
        cmd.do_clear = in_fire;
      end
      sfs_pkg::ACT_LOAD: begin
        req.accepted = chan_in_range && sfs_pkg::fnum_ok(in_frame_number);
        cmd.do_load  = in_fire && req.accepted;
      end
      default: begin
        req.accepted = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      commit_r <= 1'b0;
    end else begin
      commit_r <= cmd.do_tick;
    end
  end

  for (genvar c = 0; c < sfs_pkg::LANES; c++) begin : g_lane
    sfs_lane u_lane (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .sel         (in_battler == sfs_pkg::CH_W'(c)),
      .can_present (in_can_present_mask[c]),
      .stage_ok    (in_stage_ok_mask[c]),
      .res         (lane_res[c])
    );
  end

  sfs_merge u_merge (
    .clk             (clk),
    .rst_n           (rst_n),
    .req             (req),
    .lane_res        (lane_res),
    .out_stall       (out_stall),
    .can_accept      (can_accept),
    .out_valid       (out_valid),
    .out_battler     (out_battler),
    .out_shown       (out_shown),
    .out_buffer_slot (out_buffer_slot),
    .out_shown_frame (out_shown_frame),
    .out_accepted    (out_accepted),
    .out_last_result (out_last_result)
  );

  assign blank_fields = !out_buffer_slot && (out_shown_frame == '0);

  `SFS_ASSERT_NXT(a_no_accept_during_commit, in_fire && (in_action == sfs_pkg::ACT_TICK), !in_fire)
  `SFS_ASSERT_IMP(a_hidden_result_zero, out_valid && !out_shown, blank_fields)
  `SFS_ASSERT_IMP(a_shown_only_on_tick, out_valid && out_shown, !out_accepted)

endmodule

`default_nettype wire
